// ----- rtl/scope_envelope_column_spans_top_assert.svh -----
// assertion macros shared by the envelope span rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef SCOPE_ENVELOPE_COLUMN_SPANS_TOP_ASSERT_SVH
`define SCOPE_ENVELOPE_COLUMN_SPANS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SEC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SEC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/scope_env_pkg.sv -----
// types, widths and constants for the envelope span block
// no dependencies
`default_nettype none
package scope_env_pkg;

  localparam int ROWS    = 256;
  localparam int COLUMNS = 512;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int SHADE_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] CENTER_ROW_RESET  = 9'd128;
  localparam logic [CFG_W-1:0] SPAN_HEIGHT_RESET = 9'd256;

  localparam int CNT_W   = $clog2(COLUMNS);
  localparam int PROD_W  = SAMPLE_W + CFG_W + 1;
  localparam int MAG_W   = PROD_W - 1;
  localparam int LO_W    = 16;
  localparam int QHI_W   = MAG_W - LO_W;
  localparam int REM_W   = LO_W + 1;
  localparam int QUO_W   = QHI_W + 1;
  localparam int DIV_K   = 65533;
  localparam int CROW_W  = $clog2(ROWS);
  localparam int RROW_W  = (CROW_W > 10) ? CROW_W + 2 : 12;
  localparam int SHADE_SCALE = 16;
  localparam int SPAN4_W = CROW_W + 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mx;
    logic signed [SAMPLE_W-1:0] mn;
    logic [CNT_W-1:0]           col;
  } adj_t;

  typedef struct packed {
    logic signed [RROW_W-1:0] top;
    logic signed [RROW_W-1:0] bot;
    logic [CNT_W-1:0]         col;
  } row_t;

endpackage
`default_nettype wire

// ----- rtl/scope_env_front.sv -----
// input register, trace joining against the previous pair, column counter
// depends on scope_env_pkg
`default_nettype none
`include "scope_envelope_column_spans_top_assert.svh"
module scope_env_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [scope_env_pkg::SAMPLE_W-1:0] max_sample,
  input  wire logic signed [scope_env_pkg::SAMPLE_W-1:0] min_sample,
  input  wire logic                                  frame_start,
  output logic                                       down_valid,
  input  wire logic                                  down_ready,
  output scope_env_pkg::adj_t                        down
);
  import scope_env_pkg::*;

  logic                       s0_valid;
  logic signed [SAMPLE_W-1:0] s0_mx;
  logic signed [SAMPLE_W-1:0] s0_mn;
  logic                       s0_fs;
  logic signed [SAMPLE_W-1:0] pmax;
  logic signed [SAMPLE_W-1:0] pmin;
  logic [CNT_W-1:0]           count;
  logic                       s1_ready;
  logic                       s0_go;
  logic                       full;
  logic signed [SAMPLE_W-1:0] amx;
  logic signed [SAMPLE_W-1:0] amn;

  assign s1_ready = !down_valid || down_ready;
  assign in_ready = !s0_valid || s1_ready;
  assign s0_go    = s0_valid && s1_ready;
  assign full     = count >= CNT_W'(COLUMNS - 1);

  always_comb begin
    amn = (s0_mx > pmax && s0_mn > pmax) ? pmax : s0_mn;
    amx = (s0_mx < pmin && amn < pmin) ? pmin : s0_mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s0_mx <= max_sample;
      s0_mn <= min_sample;
      s0_fs <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pmax       <= '0;
      pmin       <= '0;
      count      <= '0;
      down_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        down_valid <= s0_valid && !s0_fs && !full;
      end
      if (s0_go) begin
        if (s0_fs) begin
          pmax  <= s0_mx;
          pmin  <= s0_mn;
          count <= '0;
        end else if (!full) begin
          pmax  <= amx;
          pmin  <= amn;
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      down.mx  <= amx;
      down.mn  <= amn;
      down.col <= count;
    end
  end

  `SEC_ASSERT_NEXT(a_seed_clears_count, clk, rst, s0_go && s0_fs, count == '0, "seed did not clear column count")
  `SEC_ASSERT_IMP(a_count_in_range, clk, rst, 1'b1, count <= CNT_W'(COLUMNS - 1), "column count past last column")

endmodule
`default_nettype wire

// ----- rtl/scope_env_rows.sv -----
// sample to row mapping: scale multiply, divide by 65533, offset from center
// depends on scope_env_pkg
`default_nettype none
module scope_env_rows (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [scope_env_pkg::CFG_W-1:0] center_row,
  input  wire logic [scope_env_pkg::CFG_W-1:0] span_height,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire scope_env_pkg::adj_t           up,
  output logic                               down_valid,
  input  wire logic                          down_ready,
  output scope_env_pkg::row_t                down
);
  import scope_env_pkg::*;

  function automatic logic [QUO_W-1:0] div_k(input logic [MAG_W-1:0] mag);
    logic [QHI_W-1:0] q0;
    logic [REM_W-1:0] rem;
    q0  = mag[MAG_W-1:LO_W];
    rem = REM_W'(mag[LO_W-1:0]) + REM_W'({q0, 1'b0}) + REM_W'(q0);
    div_k = QUO_W'(q0) + QUO_W'(rem >= REM_W'(DIV_K));
  endfunction

  function automatic logic [MAG_W-1:0] abs_p(input logic signed [PROD_W-1:0] p);
    abs_p = p[PROD_W-1] ? MAG_W'(-p) : MAG_W'(p);
  endfunction

  function automatic logic signed [RROW_W-1:0] to_row(
    input logic [CFG_W-1:0] c, input logic neg, input logic [QUO_W-1:0] q);
    logic signed [RROW_W-1:0] ce;
    logic signed [RROW_W-1:0] qe;
    ce = RROW_W'(c);
    qe = RROW_W'(q);
    to_row = neg ? ce + qe : ce - qe;
  endfunction

  logic                     m_valid;
  logic signed [PROD_W-1:0] m_pmx;
  logic signed [PROD_W-1:0] m_pmn;
  logic [CNT_W-1:0]         m_col;
  logic                     q_valid;
  logic [QUO_W-1:0]         q_mx;
  logic [QUO_W-1:0]         q_mn;
  logic                     q_mx_neg;
  logic                     q_mn_neg;
  logic [CNT_W-1:0]         q_col;
  logic                     m_ready;
  logic                     q_ready;
  logic                     r_ready;
  logic signed [CFG_W:0]    span_s;

  assign span_s   = $signed({1'b0, span_height});
  assign r_ready  = !down_valid || down_ready;
  assign q_ready  = !q_valid || r_ready;
  assign m_ready  = !m_valid || q_ready;
  assign up_ready = m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      q_valid    <= 1'b0;
      down_valid <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid <= up_valid;
      end
      if (q_ready) begin
        q_valid <= m_valid;
      end
      if (r_ready) begin
        down_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && up_valid) begin
      m_pmx <= PROD_W'(up.mx) * PROD_W'(span_s);
      m_pmn <= PROD_W'(up.mn) * PROD_W'(span_s);
      m_col <= up.col;
    end
    if (q_ready && m_valid) begin
      q_mx     <= div_k(abs_p(m_pmx));
      q_mn     <= div_k(abs_p(m_pmn));
      q_mx_neg <= m_pmx[PROD_W-1];
      q_mn_neg <= m_pmn[PROD_W-1];
      q_col    <= m_col;
    end
    if (r_ready && q_valid) begin
      down.top <= to_row(center_row, q_mx_neg, q_mx);
      down.bot <= to_row(center_row, q_mn_neg, q_mn);
      down.col <= q_col;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/scope_env_emit.sv -----
// clamping, skip decisions, shade and the result register
// depends on scope_env_pkg
`default_nettype none
`include "scope_envelope_column_spans_top_assert.svh"
module scope_env_emit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              up_valid,
  output logic                                   up_ready,
  input  wire scope_env_pkg::row_t               up,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [scope_env_pkg::COL_W-1:0]        column,
  output logic [scope_env_pkg::ROW_W-1:0]        top_row,
  output logic [scope_env_pkg::ROW_W-1:0]        bottom_row,
  output logic [scope_env_pkg::SHADE_W-1:0]      shade
);
  import scope_env_pkg::*;

  localparam logic signed [RROW_W-1:0] RowsS = RROW_W'(ROWS);

  logic               top_lo;
  logic               top_hi;
  logic               bot_lo;
  logic               bot_hi;
  logic [CROW_W-1:0]  top_c;
  logic [CROW_W-1:0]  bot_c;
  logic [CROW_W-1:0]  span_c;
  logic [SPAN4_W-1:0] shade_full;
  logic               keep;

  assign up_ready = !out_valid || out_ready;

  always_comb begin
    top_lo = up.top[RROW_W-1];
    top_hi = !top_lo && (up.top >= RowsS);
    bot_lo = up.bot[RROW_W-1];
    bot_hi = !bot_lo && (up.bot >= RowsS);
    priority if (top_lo) begin
      top_c = '0;
    end else if (top_hi) begin
      top_c = CROW_W'(ROWS - 1);
    end else begin
      top_c = CROW_W'(up.top);
    end
    priority if (bot_lo) begin
      bot_c = '0;
    end else if (bot_hi) begin
      bot_c = CROW_W'(ROWS - 1);
    end else begin
      bot_c = CROW_W'(up.bot);
    end
    span_c     = bot_c - top_c;
    shade_full = SPAN4_W'((SPAN4_W'(span_c) * SHADE_SCALE) / ROWS);
    keep       = !((top_lo || top_hi) && (bot_lo || bot_hi)) && (bot_c >= top_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      column     <= COL_W'(up.col);
      top_row    <= ROW_W'(top_c);
      bottom_row <= ROW_W'(bot_c);
      shade      <= shade_full[SHADE_W-1:0];
    end
  end

  `SEC_ASSERT_IMP(a_span_ordered, clk, rst, out_valid, top_row <= bottom_row, "result span has top below bottom")

endmodule
`default_nettype wire

// ----- rtl/scope_envelope_column_spans_top.sv -----
// Min/max envelope span renderer: one vertical span per display column.
// Input channel (in_valid/in_ready) transfers one max/min sample pair with
// frame_start; a pair with frame_start set only seeds the trace history and
// restarts the column count. Each later pair is joined to the previous one,
// mapped to rows, clamped and sent on the output channel (out_valid/out_ready)
// as column, top_row, bottom_row and shade, unless both rows lie off screen,
// the span is negative, or the frame's columns are used up.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes center_row
// (index 0) and span_height (index 1); write only while the block is idle.
// Path: a result passes the input register, join, multiply, divide and row
// stages and the result register before it shows on out_valid.
// Throughput: one pair per cycle while out_ready does not hold results back;
// the joining compare-and-select and the column counter are the feedback loops.
// Reset: center_row 128, span_height 256, history and column count zero,
// pipeline empty. When out_ready stays low, stages fill behind the held
// result and in_ready drops once every stage holds an item.
// depends on scope_env_pkg, scope_env_front, scope_env_rows, scope_env_emit
`default_nettype none
module scope_envelope_column_spans_top (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [scope_env_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [scope_env_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic signed [scope_env_pkg::SAMPLE_W-1:0] max_sample,
  input  wire logic signed [scope_env_pkg::SAMPLE_W-1:0] min_sample,
  input  wire logic                                      frame_start,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic [scope_env_pkg::COL_W-1:0]                column,
  output logic [scope_env_pkg::ROW_W-1:0]                top_row,
  output logic [scope_env_pkg::ROW_W-1:0]                bottom_row,
  output logic [scope_env_pkg::SHADE_W-1:0]              shade
);
  import scope_env_pkg::*;

  logic [CFG_W-1:0] center_row;
  logic [CFG_W-1:0] span_height;
  logic             adj_valid;
  logic             adj_ready;
  adj_t             adj;
  logic             row_valid;
  logic             row_ready;
  row_t             row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_row  <= CENTER_ROW_RESET;
      span_height <= SPAN_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_ROW:  center_row  <= cfg_data;
        REG_SPAN_HEIGHT: span_height <= cfg_data;
      endcase
    end
  end

  scope_env_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .max_sample (max_sample),
    .min_sample (min_sample),
    .frame_start(frame_start),
    .down_valid (adj_valid),
    .down_ready (adj_ready),
    .down       (adj)
  );

  scope_env_rows u_rows (
    .clk        (clk),
    .rst        (rst),
    .center_row (center_row),
    .span_height(span_height),
    .up_valid   (adj_valid),
    .up_ready   (adj_ready),
    .up         (adj),
    .down_valid (row_valid),
    .down_ready (row_ready),
    .down       (row)
  );

  scope_env_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (row_valid),
    .up_ready  (row_ready),
    .up        (row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .column    (column),
    .top_row   (top_row),
    .bottom_row(bottom_row),
    .shade     (shade)
  );

endmodule
`default_nettype wire
